### design/cbd_pkg.sv
// Shared operation codes and cell control type for the deque.
package cbd_pkg;

  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  // Broadcast to every cell of the chain at the same time.
  typedef struct packed {
    logic shift_up;    // take the word of the lower neighbor (push front)
    logic shift_down;  // take the word of the upper neighbor (pop front)
  } cell_ctl_t;

endpackage

### design/cbd_cell.sv
// One storage cell of the deque chain.
module cbd_cell #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  cbd_pkg::cell_ctl_t  ctl_i,
  input  logic                wr_i,     // load the pushed word here
  input  logic                rd_i,     // this cell holds the back word
  input  logic [W-1:0]        push_i,
  input  logic [W-1:0]        below_i,
  input  logic [W-1:0]        above_i,
  output logic [W-1:0]        data_o,
  output logic [W-1:0]        tap_o
);

  logic [W-1:0] data_q;
  logic [W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_up) begin
      data_d = below_i;
    end else if (ctl_i.shift_down) begin
      data_d = above_i;
    end else if (wr_i) begin
      data_d = push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = rd_i ? data_q : '0;

endmodule

### design/circular_buffer_deque.sv
// Top level of the double-ended queue built as a chain of word cells.
//
//  channel | dir | fields (low bit first)                              | handshake
//  --------+-----+------------------------------------------------------+-----------------------
//  s_axis  | in  | op[2:0], push_value[34:3], zero pad to 40 bits         | tvalid & tready
//  m_axis  | out | ok, front[32:1], back[64:33], count[68:65],            | tvalid & tready
//          |     | empty[69], full[70], zero pad to 72 bits               |
//
// Per transaction, the cell chain and count update at the accept edge and set the busy
// flag; the busy flag then loads the result register, with the back word gathered from
// the cells through an AND-OR of their taps.
// rst_ni clears the count, the busy flag and the result valid; cell words are not reset.
// A stalled result holds in its register; the next transaction is taken in the same
// cycle that the result drains.
module circular_buffer_deque #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // op[2:0], push_value[34:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // ok, front, back, count, empty, full
);

  localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;  // stored word width
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic          accept;
  logic [2:0]    op;
  logic [SW-1:0] push_val;
  logic          is_full_now;
  logic          is_empty_now;

  logic [CW-1:0] count_q, count_d;
  logic          pend_q;
  logic          ok_q, ok_d;
  logic          m_tvalid_q;
  logic [71:0]   m_tdata_q;

  cbd_pkg::cell_ctl_t ctl;
  logic          wr_back;

  logic [SW-1:0] cell_data [DEPTH];
  logic [SW-1:0] cell_tap  [DEPTH];
  logic [SW-1:0] back_word;

  assign op       = s_axis_tdata[2:0];
  assign push_val = s_axis_tdata[3 +: SW];

  // Take a new transaction only when no result is pending and the output is free.
  assign s_axis_tready = !pend_q && (!m_tvalid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign is_full_now  = (count_q == FULL_CNT);
  assign is_empty_now = (count_q == '0);

  // Decode the operation; refused ones leave the chain and count alone.
  always_comb begin
    ctl     = '0;
    wr_back = 1'b0;
    ok_d    = 1'b0;
    count_d = count_q;
    if (accept) begin
      case (op)
        cbd_pkg::OP_PUSH_BACK: begin
          if (!is_full_now) begin
            wr_back = 1'b1;
            count_d = count_q + 1'b1;
            ok_d    = 1'b1;
          end
        end
        cbd_pkg::OP_PUSH_FRONT: begin
          if (!is_full_now) begin
            ctl.shift_up = 1'b1;
            count_d      = count_q + 1'b1;
            ok_d         = 1'b1;
          end
        end
        cbd_pkg::OP_POP_BACK: begin
          if (!is_empty_now) begin
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
          end
        end
        cbd_pkg::OP_POP_FRONT: begin
          if (!is_empty_now) begin
            ctl.shift_down = 1'b1;
            count_d        = count_q - 1'b1;
            ok_d           = 1'b1;
          end
        end
        cbd_pkg::OP_QUERY: begin
          ok_d = 1'b1;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  // Cell 0 is the front; the back sits at cell count-1.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SW-1:0] below;
    logic [SW-1:0] above;
    if (i == 0) begin : g_first
      assign below = push_val;
    end else begin : g_mid
      assign below = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = cell_data[i];
    end else begin : g_inner
      assign above = cell_data[i+1];
    end

    cbd_cell #(.W(SW)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .wr_i   (wr_back && (count_q == CW'(i))),
      .rd_i   (count_q == CW'(i + 1)),
      .push_i (push_val),
      .below_i(below),
      .above_i(above),
      .data_o (cell_data[i]),
      .tap_o  (cell_tap[i])
    );
  end

  // Gather the back word; at most one cell taps out, none when empty.
  always_comb begin
    back_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      back_word = back_word | cell_tap[k];
    end
  end

  logic [SW+31:0] front_ext;
  logic [SW+31:0] back_ext;
  logic [CW+3:0]  count_ext;

  assign front_ext = {32'd0, (is_empty_now ? {SW{1'b0}} : cell_data[0])};
  assign back_ext  = {32'd0, back_word};
  assign count_ext = {4'd0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      pend_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= accept;
      if (pend_q) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // Hold the ok flag from the accept edge until the result loads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q <= ok_d;
    end
    if (pend_q) begin
      m_tdata_q <= {1'b0, is_full_now, is_empty_now, count_ext[3:0],
                    back_ext[31:0], front_ext[31:0], ok_q};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("deque count exceeds depth");

  a_pend_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> m_axis_tvalid)
    else $error("pending result not loaded");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !s_axis_tready)
    else $error("transaction accepted while result pending");

  a_full_push_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_full_now &&
     (op == cbd_pkg::OP_PUSH_BACK || op == cbd_pkg::OP_PUSH_FRONT))
    |=> (count_q == FULL_CNT) && !ok_q)
    else $error("push on full deque changed state");

  a_empty_pop_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_empty_now &&
     (op == cbd_pkg::OP_POP_BACK || op == cbd_pkg::OP_POP_FRONT))
    |=> (count_q == '0) && !ok_q)
    else $error("pop on empty deque changed state");

endmodule
